// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry concurrent checks.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that an expression is never true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: hw/rtl/i2cmrt_pkg.sv
// Types, codes and constants of the I2C master register transfer block.
// No dependencies; imported by every module of the block.
package i2cmrt_pkg;

    localparam int BUFFER_DEPTH = 16;
    localparam int BUF_AW = $clog2(BUFFER_DEPTH);
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] MODE_LOAD = 3'd0;
    localparam logic [2:0] MODE_START_READ = 3'd1;
    localparam logic [2:0] MODE_START_WRITE = 3'd2;
    localparam logic [2:0] MODE_TX_READY = 3'd3;
    localparam logic [2:0] MODE_RX_BYTE = 3'd4;

    localparam logic [2:0] ACT_START = 3'd0;
    localparam logic [2:0] ACT_SEND = 3'd1;
    localparam logic [2:0] ACT_RESTART_RX = 3'd2;
    localparam logic [2:0] ACT_STOP = 3'd3;
    localparam logic [2:0] ACT_RECEIVED = 3'd4;
    localparam logic [2:0] ACT_COMPLETE = 3'd5;

    localparam logic [2:0] CODE_IDLE = 3'd0;
    localparam logic [2:0] CODE_SEND_REG = 3'd1;
    localparam logic [2:0] CODE_SWITCH_RX = 3'd2;
    localparam logic [2:0] CODE_SEND_DATA = 3'd3;
    localparam logic [2:0] CODE_RECEIVE = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE      = 5'b00001,
        ST_SEND_REG  = 5'b00010,
        ST_SWITCH_RX = 5'b00100,
        ST_SEND_DATA = 5'b01000,
        ST_RECEIVE   = 5'b10000
    } t_ctrl_state;

    typedef struct packed {
        logic [2:0] mode;
        logic [6:0] dev_address;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic [3:0] byte_index;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] byte_value;
        logic [7:0] received_index;
        logic [2:0] controller_state;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic      pair;
        t_out_item first;
        t_out_item second;
    } t_q_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [2:0] state_code(t_ctrl_state st);
        logic [2:0] code;
        case (st)
            ST_IDLE:      code = CODE_IDLE;
            ST_SEND_REG:  code = CODE_SEND_REG;
            ST_SWITCH_RX: code = CODE_SWITCH_RX;
            ST_SEND_DATA: code = CODE_SEND_DATA;
            ST_RECEIVE:   code = CODE_RECEIVE;
            default:      code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// File: hw/rtl/i2cmrt_front.sv
// Front part: accepts requests, runs the transfer sequencer and holds the write buffer.
// Depends on i2cmrt_pkg; pushes result pairs into i2cmrt_fifo.
module i2cmrt_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  i2cmrt_pkg::t_in_item  i_in_item,
    input  i2cmrt_pkg::t_q_status i_q_status,
    output logic                  o_push,
    output i2cmrt_pkg::t_q_entry  o_push_entry
);
    import i2cmrt_pkg::*;

    t_ctrl_state r_state, n_state;
    logic [7:0]  r_pending_register, n_pending_register;
    logic [7:0]  r_receive_remaining, n_receive_remaining;
    logic [7:0]  r_receive_position, n_receive_position;
    logic [4:0]  r_send_remaining, n_send_remaining;
    logic [3:0]  r_send_position, n_send_position;
    logic [7:0]  r_write_buffer [BUFFER_DEPTH];
    logic [7:0]  r_send_byte;

    logic        s_accept;
    logic        s_buf_we;
    logic [1:0]  s_count;
    t_out_item   s_first;
    t_out_item   s_second;
    t_out_item   s_tail;
    logic        s_has_tail;
    logic [7:0]  s_rem_after;
    logic [4:0]  s_clamped;

    assign o_in_ready = !i_q_status.full;
    assign s_accept = i_in_valid && o_in_ready;
    assign s_clamped = (i_in_item.byte_count > 8'(BUFFER_DEPTH)) ?
                       5'(BUFFER_DEPTH) : i_in_item.byte_count[4:0];

    always_comb begin
        n_state = r_state;
        n_pending_register = r_pending_register;
        n_receive_remaining = r_receive_remaining;
        n_receive_position = r_receive_position;
        n_send_remaining = r_send_remaining;
        n_send_position = r_send_position;
        s_buf_we = 1'b0;
        s_count = 2'd0;
        s_first = '0;
        s_second = '0;
        s_tail = '0;
        s_has_tail = 1'b0;
        s_rem_after = r_receive_remaining;
        if (s_accept) begin
            case (i_in_item.mode)
                MODE_LOAD: begin
                    if ({5'd0, i_in_item.byte_index} < 9'(BUFFER_DEPTH)) begin
                        s_buf_we = 1'b1;
                    end
                end
                MODE_START_READ, MODE_START_WRITE: begin
                    n_state = ST_SEND_REG;
                    n_pending_register = i_in_item.register_address;
                    n_receive_position = 8'd0;
                    n_send_position = 4'd0;
                    if (i_in_item.mode == MODE_START_READ) begin
                        n_receive_remaining = i_in_item.byte_count;
                        n_send_remaining = 5'd0;
                    end else begin
                        n_receive_remaining = 8'd0;
                        n_send_remaining = s_clamped;
                    end
                    s_first.action = ACT_START;
                    s_first.byte_value = {1'b0, i_in_item.dev_address};
                    s_count = 2'd1;
                end
                MODE_TX_READY: begin
                    case (r_state)
                        ST_SEND_REG: begin
                            n_state = (r_receive_remaining != 8'd0) ? ST_SWITCH_RX : ST_SEND_DATA;
                            s_first.action = ACT_SEND;
                            s_first.byte_value = r_pending_register;
                            s_count = 2'd1;
                        end
                        ST_SWITCH_RX: begin
                            n_state = ST_RECEIVE;
                            s_first.action = ACT_RESTART_RX;
                            s_second.action = ACT_STOP;
                            s_count = (r_receive_remaining == 8'd1) ? 2'd2 : 2'd1;
                        end
                        ST_SEND_DATA: begin
                            if (r_send_remaining != 5'd0) begin
                                s_first.action = ACT_SEND;
                                s_first.byte_value = r_send_byte;
                                n_send_position = r_send_position + 4'd1;
                                n_send_remaining = r_send_remaining - 5'd1;
                                s_count = 2'd1;
                            end else begin
                                n_state = ST_IDLE;
                                s_first.action = ACT_STOP;
                                s_second.action = ACT_COMPLETE;
                                s_count = 2'd2;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                MODE_RX_BYTE: begin
                    if (r_state == ST_RECEIVE) begin
                        if (r_receive_remaining != 8'd0) begin
                            s_rem_after = r_receive_remaining - 8'd1;
                        end
                        if (s_rem_after == 8'd1) begin
                            s_has_tail = 1'b1;
                            s_tail.action = ACT_STOP;
                        end else if (s_rem_after == 8'd0) begin
                            s_has_tail = 1'b1;
                            s_tail.action = ACT_COMPLETE;
                            n_state = ST_IDLE;
                        end
                        if (r_receive_remaining != 8'd0) begin
                            n_receive_remaining = s_rem_after;
                            n_receive_position = r_receive_position + 8'd1;
                            s_first.action = ACT_RECEIVED;
                            s_first.byte_value = i_in_item.data_byte;
                            s_first.received_index = r_receive_position;
                            s_second = s_tail;
                            s_count = s_has_tail ? 2'd2 : 2'd1;
                        end else begin
                            s_first = s_tail;
                            s_count = s_has_tail ? 2'd1 : 2'd0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
        s_first.controller_state = state_code(n_state);
        s_second.controller_state = state_code(n_state);
        s_first.last = (s_count == 2'd1);
        s_second.last = 1'b1;
    end

    assign o_push = (s_count != 2'd0);
    assign o_push_entry = '{pair: (s_count == 2'd2), first: s_first, second: s_second};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pending_register <= 8'd0;
            r_receive_remaining <= 8'd0;
            r_receive_position <= 8'd0;
            r_send_remaining <= 5'd0;
            r_send_position <= 4'd0;
        end else begin
            r_state <= n_state;
            r_pending_register <= n_pending_register;
            r_receive_remaining <= n_receive_remaining;
            r_receive_position <= n_receive_position;
            r_send_remaining <= n_send_remaining;
            r_send_position <= n_send_position;
        end
    end

    // The byte at the next send position is fetched into a register ahead of its use, with a
    // load to that same slot passed straight through.
    always_ff @(posedge i_clk) begin
        if (s_buf_we) begin
            r_write_buffer[i_in_item.byte_index[BUF_AW-1:0]] <= i_in_item.data_byte;
        end
        if (s_buf_we && (i_in_item.byte_index == n_send_position)) begin
            r_send_byte <= i_in_item.data_byte;
        end else begin
            r_send_byte <= r_write_buffer[n_send_position[BUF_AW-1:0]];
        end
    end

endmodule

// File: hw/rtl/i2cmrt_fifo.sv
// Short queue of result entries between the front and back parts.
// Depends on i2cmrt_pkg for the entry and status types.
module i2cmrt_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  i2cmrt_pkg::t_q_entry  i_push_entry,
    input  logic                  i_pop,
    output i2cmrt_pkg::t_q_entry  o_head,
    output i2cmrt_pkg::t_q_status o_status
);
    import i2cmrt_pkg::*;

    t_q_entry            r_entries [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]   r_count, n_count;
    logic                s_do_push;
    logic                s_do_pop;

    assign o_status.full = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign s_do_push = i_push && !o_status.full;
    assign s_do_pop = i_pop && !o_status.empty;
    assign o_head = r_entries[r_rd_ptr];

    always_comb begin
        n_wr_ptr = s_do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = s_do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count = r_count;
        if (s_do_push && !s_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (s_do_pop && !s_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_do_push) begin
            r_entries[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule

// File: hw/rtl/i2cmrt_back.sv
// Back part: hands queued result entries to the output channel one result at a time.
// Depends on i2cmrt_pkg; reads the head of i2cmrt_fifo.
module i2cmrt_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  i2cmrt_pkg::t_q_entry  i_head,
    input  i2cmrt_pkg::t_q_status i_q_status,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output i2cmrt_pkg::t_out_item o_out_item
);
    import i2cmrt_pkg::*;

    logic r_second, n_second;
    logic s_take;

    assign o_out_valid = !i_q_status.empty;
    assign o_out_item = r_second ? i_head.second : i_head.first;
    assign s_take = o_out_valid && i_out_ready;
    assign o_pop = s_take && (!i_head.pair || r_second);

    always_comb begin
        n_second = r_second;
        if (s_take) begin
            n_second = i_head.pair && !r_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else begin
            r_second <= n_second;
        end
    end

endmodule

// File: hw/rtl/i2c_master_register_transfer.sv
// I2C master register read/write sequencer: a request is taken in every cycle while the
// four-entry result queue between the sequencer and the output side has room. Results
// leave one per cycle while the output is ready, so a request that causes two results
// takes two output transfers; requests that cause no result never enter the queue.
// Depends on i2cmrt_pkg, i2cmrt_front, i2cmrt_fifo, i2cmrt_back and assert_macros.svh.
`include "assert_macros.svh"

module i2c_master_register_transfer (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  i2cmrt_pkg::t_in_item  i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output i2cmrt_pkg::t_out_item o_out_item
);
    import i2cmrt_pkg::*;

    logic      s_push;
    t_q_entry  s_push_entry;
    logic      s_pop;
    t_q_entry  s_head;
    t_q_status s_q_status;
    logic      s_pair_head;
    logic      s_pair_tail;

    i2cmrt_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_q_status   (s_q_status),
        .o_push       (s_push),
        .o_push_entry (s_push_entry)
    );

    i2cmrt_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (s_push),
        .i_push_entry (s_push_entry),
        .i_pop        (s_pop),
        .o_head       (s_head),
        .o_status     (s_q_status)
    );

    i2cmrt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (s_head),
        .i_q_status  (s_q_status),
        .o_pop       (s_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    assign s_pair_head = o_out_valid && i_out_ready && !o_out_item.last;
    assign s_pair_tail = o_out_valid && o_out_item.last &&
                         (o_out_item.action == ACT_STOP || o_out_item.action == ACT_COMPLETE);

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, s_push && s_q_status.full, "queue overflow")
    `ASSERT_ALWAYS(a_pair_tail, i_clk, i_rst_n, s_pair_head |=> s_pair_tail, "pair tail missing")

endmodule

// File: tb/i2cmrt_checker.sv
// Checker for the I2C master register transfer block: watches the request and
// result channels, predicts the bus actions of each request and compares them in order.
// Depends on i2cmrt_pkg for the request and result types and codes.
`timescale 1ns / 100ps

module i2cmrt_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  i2cmrt_pkg::t_in_item  i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  i2cmrt_pkg::t_out_item i_out_item,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);
    import i2cmrt_pkg::*;

    logic [2:0] seq_state;
    logic [7:0] held_register;
    logic [7:0] rx_left;
    logic [7:0] rx_pos;
    logic [4:0] tx_left;
    logic [3:0] tx_pos;
    logic [7:0] tx_buffer [BUFFER_DEPTH];

    t_out_item pending_actions [$];
    int        failures = 0;
    int        checked = 0;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_checked = 0;
    end

    function automatic t_out_item bus_action(input logic [2:0] action, input logic [7:0] value,
                                             input logic [7:0] index);
        t_out_item r;
        r.action = action;
        r.byte_value = value;
        r.received_index = index;
        r.controller_state = seq_state;
        r.last = 1'b0;
        return r;
    endfunction

    task automatic open_transfer(input logic [7:0] reg_byte, input logic [7:0] rx_count,
                                 input logic [4:0] tx_count);
        seq_state = CODE_SEND_REG;
        held_register = reg_byte;
        rx_left = rx_count;
        rx_pos = 8'd0;
        tx_left = tx_count;
        tx_pos = 4'd0;
    endtask

    task automatic advance_sequencer(input t_in_item req);
        t_out_item  made [2];
        int         n;
        int         k;
        logic [7:0] clamped;
        logic [7:0] idx;
        n = 0;
        made[0] = '0;
        made[1] = '0;
        case (req.mode)
            MODE_LOAD: begin
                if (int'(req.byte_index) < BUFFER_DEPTH) begin
                    tx_buffer[req.byte_index] = req.data_byte;
                end
            end
            MODE_START_READ: begin
                open_transfer(req.register_address, req.byte_count, 5'd0);
                made[n] = bus_action(ACT_START, {1'b0, req.dev_address}, 8'd0);
                n++;
            end
            MODE_START_WRITE: begin
                clamped = (int'(req.byte_count) > BUFFER_DEPTH) ? 8'(BUFFER_DEPTH)
                                                                : req.byte_count;
                open_transfer(req.register_address, 8'd0, clamped[4:0]);
                made[n] = bus_action(ACT_START, {1'b0, req.dev_address}, 8'd0);
                n++;
            end
            MODE_TX_READY: begin
                if (seq_state == CODE_SEND_REG) begin
                    seq_state = (rx_left != 8'd0) ? CODE_SWITCH_RX : CODE_SEND_DATA;
                    made[n] = bus_action(ACT_SEND, held_register, 8'd0);
                    n++;
                end else if (seq_state == CODE_SWITCH_RX) begin
                    seq_state = CODE_RECEIVE;
                    made[n] = bus_action(ACT_RESTART_RX, 8'd0, 8'd0);
                    n++;
                    if (rx_left == 8'd1) begin
                        made[n] = bus_action(ACT_STOP, 8'd0, 8'd0);
                        n++;
                    end
                end else if (seq_state == CODE_SEND_DATA) begin
                    if (tx_left != 5'd0) begin
                        made[n] = bus_action(ACT_SEND, tx_buffer[tx_pos], 8'd0);
                        n++;
                        tx_pos++;
                        tx_left--;
                    end else begin
                        seq_state = CODE_IDLE;
                        made[n] = bus_action(ACT_STOP, 8'd0, 8'd0);
                        n++;
                        made[n] = bus_action(ACT_COMPLETE, 8'd0, 8'd0);
                        n++;
                    end
                end
            end
            MODE_RX_BYTE: begin
                if (seq_state == CODE_RECEIVE) begin
                    if (rx_left != 8'd0) begin
                        idx = rx_pos;
                        rx_pos++;
                        rx_left--;
                        if (rx_left == 8'd0) begin
                            seq_state = CODE_IDLE;
                        end
                        made[n] = bus_action(ACT_RECEIVED, req.data_byte, idx);
                        n++;
                    end
                    if (rx_left == 8'd1) begin
                        made[n] = bus_action(ACT_STOP, 8'd0, 8'd0);
                        n++;
                    end else if (rx_left == 8'd0) begin
                        seq_state = CODE_IDLE;
                        made[n] = bus_action(ACT_COMPLETE, 8'd0, 8'd0);
                        n++;
                    end
                end
            end
            default: begin
            end
        endcase
        if (n > 0) begin
            made[n - 1].last = 1'b1;
        end
        for (k = 0; k < n; k++) begin
            pending_actions.push_back(made[k]);
        end
    endtask

    task automatic compare_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            failures++;
        end
    endtask

    task automatic check_action(input t_out_item got);
        t_out_item want;
        if (pending_actions.size() == 0) begin
            $error("result with no request behind it: action %0d, byte_value %0d",
                   got.action, got.byte_value);
            failures++;
        end else begin
            want = pending_actions.pop_front();
            compare_field("action", want.action, got.action);
            compare_field("byte_value", want.byte_value, got.byte_value);
            compare_field("received_index", want.received_index, got.received_index);
            compare_field("controller_state", want.controller_state, got.controller_state);
            compare_field("last", want.last, got.last);
            checked++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            seq_state = CODE_IDLE;
            held_register = 8'd0;
            rx_left = 8'd0;
            rx_pos = 8'd0;
            tx_left = 5'd0;
            tx_pos = 4'd0;
            pending_actions.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                advance_sequencer(i_in_item);
            end
            if (i_out_valid && i_out_ready) begin
                check_action(i_out_item);
            end
        end
        o_fail_count <= failures;
        o_pending <= pending_actions.size();
        o_checked <= checked;
    end

endmodule

// File: tb/i2c_master_register_transfer_test.sv
// Top of the testbench for the I2C master register transfer block: drives directed and
// random register read and write transfers with random gaps and stalls, and gives the verdict.
// Depends on i2cmrt_pkg, the block itself and i2cmrt_checker.
`timescale 1ns / 100ps

module i2c_master_register_transfer_test;
    import i2cmrt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TARGET_REQUESTS = 2000;

    logic      clk;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    int fail_count;
    int pending;
    int checked;
    int cycle_count = 0;
    int request_count = 0;
    int transfer_requests = 0;
    int transfer_count = 0;
    bit quiet = 1'b0;

    i2c_master_register_transfer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    i2cmrt_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("i2c_master_register_transfer_test NOT OK");
            $finish;
        end
    end

    initial begin
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            @(posedge clk);
            out_ready <= quiet || ($urandom_range(0, 99) >= 26);
        end
    end

    function automatic t_in_item random_request();
        t_in_item r;
        r.mode = 3'($urandom_range(0, 7));
        r.dev_address = 7'($urandom);
        r.register_address = 8'($urandom);
        r.byte_count = 8'($urandom);
        r.byte_index = 4'($urandom);
        r.data_byte = 8'($urandom);
        return r;
    endfunction

    function automatic t_in_item make_request(input logic [2:0] mode, input logic [6:0] dev,
                                              input logic [7:0] reg_byte,
                                              input logic [7:0] count);
        t_in_item r;
        r = random_request();
        r.mode = mode;
        r.dev_address = dev;
        r.register_address = reg_byte;
        r.byte_count = count;
        return r;
    endfunction

    task automatic send_request(input t_in_item req);
        while (!quiet && $urandom_range(0, 99) < 26) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= req;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        request_count++;
    endtask

    task automatic run_transfer();
        logic     is_read;
        int       pick;
        int       count;
        int       steps;
        int       i;
        t_in_item req;
        is_read = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            count = $urandom_range(0, 5);
        end else if (pick < 97) begin
            count = $urandom_range(6, 24);
        end else begin
            count = $urandom_range(0, 255);
        end
        req = make_request(is_read ? MODE_START_READ : MODE_START_WRITE,
                           7'($urandom), 8'($urandom), 8'(count));
        send_request(req);
        transfer_requests++;
        transfer_count++;
        if (is_read) begin
            steps = (count == 0) ? 2 : 2 + count;
        end else begin
            steps = 2 + ((count > BUFFER_DEPTH) ? BUFFER_DEPTH : count);
        end
        for (i = 0; i < steps; i++) begin
            if ($urandom_range(0, 99) < 3) begin
                return;
            end
            if ($urandom_range(0, 99) < 5) begin
                send_request(random_request());
            end
            req = random_request();
            req.mode = (is_read && i >= 2) ? MODE_RX_BYTE : MODE_TX_READY;
            send_request(req);
            transfer_requests++;
            quiet = (transfer_requests >= 800 && transfer_requests < 1100);
        end
    endtask

    initial begin
        int       k;
        t_in_item req;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Every buffer slot is loaded before any write can send it.
        for (k = 0; k < BUFFER_DEPTH; k++) begin
            req = make_request(MODE_LOAD, 7'd0, 8'd0, 8'd0);
            req.byte_index = 4'(k);
            req.data_byte = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : 8'($urandom);
            send_request(req);
        end

        // Ready and received-byte events while idle are ignored.
        send_request(make_request(MODE_TX_READY, 7'h7F, 8'hFF, 8'hFF));
        send_request(make_request(MODE_RX_BYTE, 7'h00, 8'h00, 8'h00));

        // A one-byte read gets its stop together with the repeated start.
        send_request(make_request(MODE_START_READ, 7'h00, 8'h00, 8'd1));
        send_request(make_request(MODE_TX_READY, 7'h00, 8'h00, 8'd0));
        send_request(make_request(MODE_TX_READY, 7'h00, 8'h00, 8'd0));
        req = make_request(MODE_RX_BYTE, 7'h00, 8'h00, 8'd0);
        req.data_byte = 8'hFF;
        send_request(req);

        // A read of zero bytes ends like an empty write.
        send_request(make_request(MODE_START_READ, 7'h7F, 8'hFF, 8'd0));
        send_request(make_request(MODE_TX_READY, 7'h7F, 8'hFF, 8'd0));
        send_request(make_request(MODE_TX_READY, 7'h7F, 8'hFF, 8'd0));

        // An oversized write is clamped, then abandoned by a new empty write.
        send_request(make_request(MODE_START_WRITE, 7'h7F, 8'hA5, 8'hFF));
        send_request(make_request(MODE_TX_READY, 7'h00, 8'h00, 8'd0));
        send_request(make_request(MODE_START_WRITE, 7'h00, 8'h00, 8'd0));
        send_request(make_request(MODE_TX_READY, 7'h00, 8'h00, 8'd0));
        send_request(make_request(MODE_TX_READY, 7'h00, 8'h00, 8'd0));

        // Mode codes above the last defined one are ignored.
        for (k = 1; k <= 3; k++) begin
            send_request(make_request(3'(MODE_RX_BYTE + k), 7'h55, 8'h55, 8'h55));
        end

        while (transfer_requests < TARGET_REQUESTS) begin
            if ($urandom_range(0, 99) < 10) begin
                send_request(random_request());
            end
            run_transfer();
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d requests in %0d register transfers, some broken or abandoned.",
                 request_count, transfer_count);
        $display("Checked %0d bus actions against the prediction.", checked);
        if (fail_count == 0) begin
            $display("i2c_master_register_transfer_test OK");
        end else begin
            $display("i2c_master_register_transfer_test NOT OK");
        end
        $finish;
    end

endmodule
